// ===== hw/rtl/wtenv_pkg.sv =====
// ----------------------------------------------------------------------------
// wtenv_pkg
// Shared types and constants of the wavetable attack-release envelope.
// ----------------------------------------------------------------------------
package wtenv_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int RATE_W      = 24;
  localparam int SAMPLE_W    = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int RECIP_SHIFT = 29;

  localparam int ATTACK_RATE_RST  = 65536;
  localparam int RELEASE_RATE_RST = 65536;
  localparam int PEAK_PHASE_RST   = 8388608;

  typedef enum logic [1:0] {
    MODE_REST    = 2'd0,
    MODE_ATTACK  = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_RETRIG  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CROSS_NONE  = 3'd0,
    CROSS_UP    = 3'd1,
    CROSS_DOWN  = 3'd2,
    CROSS_END   = 3'd3,
    CROSS_OTHER = 3'd4
  } crossing_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_RATE  = 2'd0,
    CFG_RELEASE_RATE = 2'd1,
    CFG_PEAK_PHASE   = 2'd2
  } cfg_index_e;

  typedef struct packed {
    mode_e     mode;
    crossing_e crossing;
  } tick_info_t;

endpackage

// ===== hw/rtl/wavetable_attack_release_envelope.sv =====
// ----------------------------------------------------------------------------
// wavetable_attack_release_envelope
// Retriggerable attack-release envelope read out of a stored wavetable.
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid / tready           tuser: kind; tdata: trigger,
//                                            table_address, table_data
//   m_axis    out  tvalid / tready           tdata: level, mode, crossing
//   cfg       in   cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// One request per cycle unless back-pressure or a configuration write stalls.
// The per-tick phase and mode update is registered at accept; the table is read
// at two addresses in the stage after, interpolated in the next.
// A configuration write holds s_axis_tready low in its cycle and the next.
// Reset starts in attack at phase zero with default rates and peak; the table
// is undefined until written.
// A stalled result leaves room for two more requests in the pipeline.
// ----------------------------------------------------------------------------
module wavetable_attack_release_envelope
  import wtenv_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int AW       = $clog2(TABLE_ENTRIES + 1),
  localparam int IN_TW    = ((1 + AW + SAMPLE_W + 7) / 8) * 8,
  localparam int OUT_TW   = ((SAMPLE_W + 2 + 3 + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_TW-1:0]     s_axis_tdata,   // trigger, table_address, table_data
  input  logic [0:0]           s_axis_tuser,   // kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_TW-1:0]    m_axis_tdata,   // level, mode, crossing
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RATE_W-1:0]    cfg_data_i
);

  localparam int SPAN = TABLE_ENTRIES << FRACTION_BITS;
  localparam int PW   = $clog2(SPAN + 1);

  logic                cfg_busy;
  logic [PW-1:0]       att_rem, rel_rem;
  logic [1:0]          att_quot, rel_quot;
  logic [RATE_W-1:0]   peak;

  logic                in_kind, in_trigger;
  logic [AW-1:0]       in_addr;
  logic [SAMPLE_W-1:0] in_data;
  logic                s_acc;
  logic [PW-1:0]       phase_d;
  tick_info_t          info_d;

  logic                adv1, adv2, out_ready;

  logic                v1_q, w1_q;
  logic [PW-1:0]       ph1_q;
  tick_info_t          info1_q;
  logic [AW-1:0]       addr1_q;
  logic [SAMPLE_W-1:0] data1_q;
  logic [AW-1:0]       idx1, nxt1;

  logic                     v2_q;
  logic [FRACTION_BITS-1:0] frac2_q;
  tick_info_t               info2_q;
  logic [SAMPLE_W-1:0]      sample_a, sample_b;

  logic [SAMPLE_W-1:0] level;
  tick_info_t          info_out;

  assign in_kind    = s_axis_tuser[0];
  assign in_trigger = s_axis_tdata[0];
  assign in_addr    = s_axis_tdata[AW:1];
  assign in_data    = s_axis_tdata[AW+SAMPLE_W:AW+1];

  assign adv2          = !v2_q || out_ready;
  assign adv1          = !v1_q || adv2;
  assign s_axis_tready = adv1 && !cfg_busy && !cfg_we_i;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  wtenv_cfg #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (cfg_we_i),
    .index_i   (cfg_index_i),
    .data_i    (cfg_data_i),
    .busy_o    (cfg_busy),
    .att_rem_o (att_rem),
    .att_quot_o(att_quot),
    .rel_rem_o (rel_rem),
    .rel_quot_o(rel_quot),
    .peak_o    (peak)
  );

  wtenv_phase #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (s_acc && !in_kind),
    .trigger_i (in_trigger),
    .att_rem_i (att_rem),
    .att_quot_i(att_quot),
    .rel_rem_i (rel_rem),
    .rel_quot_i(rel_quot),
    .peak_i    (peak),
    .phase_o   (phase_d),
    .info_o    (info_d)
  );

  // stage 1: table write or table address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= s_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && s_acc) begin
      w1_q    <= in_kind;
      ph1_q   <= phase_d;
      info1_q <= info_d;
      addr1_q <= in_addr;
      data1_q <= in_data;
    end
  end

  assign idx1 = AW'(ph1_q >> FRACTION_BITS);
  assign nxt1 = (idx1 == AW'(TABLE_ENTRIES)) ? idx1 : idx1 + AW'(1);

  wtenv_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (v1_q && w1_q && adv2 && (addr1_q <= AW'(TABLE_ENTRIES))),
    .waddr_i  (addr1_q),
    .wdata_i  (data1_q),
    .re_i     (adv2),
    .raddr_a_i(idx1),
    .raddr_b_i(nxt1),
    .rdata_a_o(sample_a),
    .rdata_b_o(sample_b)
  );

  // stage 2: samples ready in the table's read registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q && !w1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      frac2_q <= ph1_q[FRACTION_BITS-1:0];
      info2_q <= info1_q;
    end
  end

  wtenv_interp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_interp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v2_q),
    .in_ready_o (out_ready),
    .sample_a_i (sample_a),
    .sample_b_i (sample_b),
    .frac_i     (frac2_q),
    .info_i     (info2_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .level_o    (level),
    .info_o     (info_out)
  );

  assign m_axis_tdata = OUT_TW'({info_out.crossing, info_out.mode, level});

endmodule

// ===== hw/rtl/wtenv_cfg.sv =====
// ----------------------------------------------------------------------------
// wtenv_cfg
// Rate and peak registers. Rates are held reduced modulo the phase span, as a
// remainder and a saturated quotient; a write passes a capture register first.
// ----------------------------------------------------------------------------
module wtenv_cfg
  import wtenv_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int SPAN = TABLE_ENTRIES << FRACTION_BITS,
  localparam int PW   = $clog2(SPAN + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [CFG_IDX_W-1:0] index_i,
  input  logic [RATE_W-1:0]    data_i,
  output logic                 busy_o,
  output logic [PW-1:0]        att_rem_o,
  output logic [1:0]           att_quot_o,
  output logic [PW-1:0]        rel_rem_o,
  output logic [1:0]           rel_quot_o,
  output logic [RATE_W-1:0]    peak_o
);

  localparam int HW    = RATE_W - FRACTION_BITS;
  localparam int RECIP = (2 ** RECIP_SHIFT + TABLE_ENTRIES - 1) / TABLE_ENTRIES;

  localparam int ATT_Q = ATTACK_RATE_RST / SPAN;
  localparam int REL_Q = RELEASE_RATE_RST / SPAN;
  localparam logic [PW-1:0] ATT_REM_RST  = PW'(ATTACK_RATE_RST % SPAN);
  localparam logic [PW-1:0] REL_REM_RST  = PW'(RELEASE_RATE_RST % SPAN);
  localparam logic [1:0]    ATT_QUOT_RST = 2'((ATT_Q > 3) ? 3 : ATT_Q);
  localparam logic [1:0]    REL_QUOT_RST = 2'((REL_Q > 3) ? 3 : REL_Q);

  logic                     c1_valid_q;
  cfg_index_e               c1_index_q;
  logic [RATE_W-1:0]        c1_data_q;
  logic [HW-1:0]            c1_quot_q;
  logic [HW-1:0]            quot_d;
  logic [HW+RECIP_SHIFT-1:0] prod;
  logic [HW-1:0]            hi_in;
  logic [HW-1:0]            hi_q;
  logic [HW-1:0]            qt;
  logic [HW-1:0]            rem_hi;
  logic [PW-1:0]            rem;
  logic [1:0]               quot_sat;

  logic [PW-1:0]     att_rem_q, rel_rem_q;
  logic [1:0]        att_quot_q, rel_quot_q;
  logic [RATE_W-1:0] peak_q;

  // quotient of the integer part by the table length, by reciprocal
  assign hi_in  = data_i[RATE_W-1:FRACTION_BITS];
  assign prod   = (HW+RECIP_SHIFT)'(hi_in) * (HW+RECIP_SHIFT)'(RECIP);
  assign quot_d = prod[RECIP_SHIFT +: HW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_valid_q <= 1'b0;
    end else begin
      c1_valid_q <= we_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      c1_index_q <= cfg_index_e'(index_i);
      c1_data_q  <= data_i;
      c1_quot_q  <= quot_d;
    end
  end

  assign hi_q     = c1_data_q[RATE_W-1:FRACTION_BITS];
  assign qt       = c1_quot_q * HW'(TABLE_ENTRIES);
  assign rem_hi   = hi_q - qt;
  assign rem      = PW'({rem_hi, c1_data_q[FRACTION_BITS-1:0]});
  assign quot_sat = (c1_quot_q > HW'(3)) ? 2'd3 : c1_quot_q[1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_rem_q  <= ATT_REM_RST;
      att_quot_q <= ATT_QUOT_RST;
      rel_rem_q  <= REL_REM_RST;
      rel_quot_q <= REL_QUOT_RST;
      peak_q     <= RATE_W'(PEAK_PHASE_RST);
    end else if (c1_valid_q) begin
      unique case (c1_index_q)
        CFG_ATTACK_RATE: begin
          att_rem_q  <= rem;
          att_quot_q <= quot_sat;
        end
        CFG_RELEASE_RATE: begin
          rel_rem_q  <= rem;
          rel_quot_q <= quot_sat;
        end
        CFG_PEAK_PHASE: begin
          peak_q <= c1_data_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy_o     = c1_valid_q;
  assign att_rem_o  = att_rem_q;
  assign att_quot_o = att_quot_q;
  assign rel_rem_o  = rel_rem_q;
  assign rel_quot_o = rel_quot_q;
  assign peak_o     = peak_q;

endmodule

// ===== hw/rtl/wtenv_phase.sv =====
// ----------------------------------------------------------------------------
// wtenv_phase
// Envelope mode, phase and crossing state. Picks the increment, moves the phase
// forward or back, wraps it and classifies the crossing of the peak, once per tick.
// ----------------------------------------------------------------------------
module wtenv_phase
  import wtenv_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int SPAN = TABLE_ENTRIES << FRACTION_BITS,
  localparam int PW   = $clog2(SPAN + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  logic              trigger_i,
  input  logic [PW-1:0]     att_rem_i,
  input  logic [1:0]        att_quot_i,
  input  logic [PW-1:0]     rel_rem_i,
  input  logic [1:0]        rel_quot_i,
  input  logic [RATE_W-1:0] peak_i,
  output logic [PW-1:0]     phase_o,
  output tick_info_t        info_o
);

  localparam int CW = (PW > RATE_W) ? PW : RATE_W;
  localparam logic [PW:0]        SPAN_Y = (PW+1)'(SPAN);
  localparam logic signed [PW:0] SPAN_Z = (PW+1)'(SPAN);

  logic [PW-1:0] phase_q;
  mode_e         mode_q, mode_d;
  crossing_e     cross_q, cross_d;

  logic                 force_one;
  logic                 neg;
  logic [PW-1:0]        rem;
  logic [1:0]           quot;
  logic [PW-1:0]        p;
  logic [PW:0]          y;
  logic signed [PW:0]   z;
  logic [PW:0]          ph;
  logic                 wrap_end;
  logic                 wrap_start;
  logic                 new_below;
  logic                 old_below;

  always_comb begin
    mode_d    = mode_q;
    force_one = 1'b0;
    neg       = 1'b0;
    rem       = '0;
    quot      = 2'd0;
    unique case (mode_q)
      MODE_ATTACK: begin
        if (cross_q == CROSS_UP) begin
          mode_d = MODE_RELEASE;
          rem    = rel_rem_i;
          quot   = rel_quot_i;
        end else begin
          rem  = att_rem_i;
          quot = att_quot_i;
        end
      end
      MODE_RELEASE: begin
        if (trigger_i) begin
          mode_d = MODE_RETRIG;
          neg    = 1'b1;
          rem    = att_rem_i;
          quot   = att_quot_i;
        end else if (cross_q == CROSS_END) begin
          mode_d    = MODE_REST;
          force_one = 1'b1;
        end else begin
          rem  = rel_rem_i;
          quot = rel_quot_i;
        end
      end
      MODE_RETRIG: begin
        if (cross_q == CROSS_DOWN) begin
          mode_d = MODE_RELEASE;
          rem    = rel_rem_i;
          quot   = rel_quot_i;
        end else begin
          neg  = 1'b1;
          rem  = att_rem_i;
          quot = att_quot_i;
        end
      end
      MODE_REST: begin
        if (trigger_i) begin
          mode_d = MODE_ATTACK;
          rem    = att_rem_i;
          quot   = att_quot_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign p = force_one ? PW'(1) : phase_q;
  assign y = {1'b0, p} + {1'b0, rem};
  assign z = $signed({1'b0, p}) - $signed({1'b0, rem});

  // wrap with the rate held as quotient and remainder of the span
  always_comb begin
    ph         = '0;
    wrap_end   = 1'b0;
    wrap_start = 1'b0;
    if (!neg) begin
      if (quot == 2'd0) begin
        if (y <= SPAN_Y) begin
          ph = y;
        end else begin
          ph       = y - SPAN_Y;
          wrap_end = 1'b1;
        end
      end else begin
        wrap_end = 1'b1;
        if (y == '0 && quot != 2'd3) begin
          ph = SPAN_Y;
          if (quot == 2'd1) begin
            wrap_end = 1'b0;
          end
        end else if (y < SPAN_Y) begin
          ph = y;
        end else if (y == SPAN_Y) begin
          ph = (quot == 2'd1) ? SPAN_Y : '0;
        end else begin
          ph = y - SPAN_Y;
        end
      end
    end else begin
      if (quot == 2'd0) begin
        if (z >= 0) begin
          ph = z;
        end else begin
          ph         = z + SPAN_Z;
          wrap_start = 1'b1;
        end
      end else if (quot == 2'd1 && z == SPAN_Z) begin
        ph = '0;
      end else begin
        wrap_start = 1'b1;
        if (z == SPAN_Z) begin
          ph = (quot == 2'd2) ? '0 : SPAN_Y;
        end else if (z > 0) begin
          ph = z;
        end else if (z == 0) begin
          ph = (quot == 2'd1) ? '0 : SPAN_Y;
        end else begin
          ph = z + SPAN_Z;
        end
      end
    end
  end

  assign new_below = CW'(ph[PW-1:0]) < CW'(peak_i);
  assign old_below = CW'(phase_q) < CW'(peak_i);

  always_comb begin
    cross_d = CROSS_OTHER;
    if (!wrap_end && !wrap_start) begin
      if (new_below == old_below) begin
        cross_d = CROSS_NONE;
      end else if (old_below) begin
        cross_d = CROSS_UP;
      end else begin
        cross_d = CROSS_DOWN;
      end
    end else if (wrap_end && new_below && !old_below) begin
      cross_d = CROSS_END;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      mode_q  <= MODE_ATTACK;
      cross_q <= CROSS_NONE;
    end else if (tick_i) begin
      phase_q <= ph[PW-1:0];
      mode_q  <= mode_d;
      cross_q <= cross_d;
    end
  end

  assign phase_o         = ph[PW-1:0];
  assign info_o.mode     = mode_d;
  assign info_o.crossing = cross_d;

endmodule

// ===== hw/rtl/wtenv_table.sv =====
// ----------------------------------------------------------------------------
// wtenv_table
// Wavetable store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module wtenv_table
  import wtenv_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int DEPTH = TABLE_ENTRIES + 1,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [SAMPLE_W-1:0] wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_a_i,
  input  logic [AW-1:0]       raddr_b_i,
  output logic [SAMPLE_W-1:0] rdata_a_o,
  output logic [SAMPLE_W-1:0] rdata_b_o
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hw/rtl/wtenv_interp.sv =====
// ----------------------------------------------------------------------------
// wtenv_interp
// Linear interpolation between two table samples and the result register.
// ----------------------------------------------------------------------------
module wtenv_interp
  import wtenv_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_W-1:0]      sample_a_i,
  input  logic [SAMPLE_W-1:0]      sample_b_i,
  input  logic [FRACTION_BITS-1:0] frac_i,
  input  tick_info_t               info_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SAMPLE_W-1:0]      level_o,
  output tick_info_t               info_o
);

  localparam int DW = SAMPLE_W + 1;
  localparam int MW = DW + FRACTION_BITS + 1;

  logic signed [DW-1:0] diff;
  logic signed [MW-1:0] prod;
  logic signed [MW-1:0] step;
  logic [DW-1:0]        sum;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] level_q;
  tick_info_t          info_q;

  assign diff = $signed({1'b0, sample_b_i}) - $signed({1'b0, sample_a_i});
  assign prod = MW'(diff) * $signed(MW'({1'b0, frac_i}));
  assign step = prod >>> FRACTION_BITS;  // floor
  assign sum  = DW'(sample_a_i) + step[DW-1:0];

  assign in_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      level_q <= sum[SAMPLE_W-1:0];
      info_q  <= info_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign info_o      = info_q;

endmodule

// ===== dv/wavetable_attack_release_envelope_tb.sv =====
// ----------------------------------------------------------------------------
// wavetable_attack_release_envelope_tb
// Loads the wavetable, then runs a short directed pass over one envelope
// (attack to the peak, release to the span end, wrap, rest and restart),
// then random ticks, triggers and table writes under several rate and peak
// settings. Each result is checked against a behavioural envelope model.
// Random idling on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wavetable_attack_release_envelope_tb;
  import wtenv_pkg::*;

  localparam longint SPAN        = longint'(TABLE_ENTRIES_DEF) << FRACTION_BITS_DEF;
  localparam longint FRAC_MASK   = (longint'(1) << FRACTION_BITS_DEF) - 1;
  localparam int     CYCLE_LIMIT = 400000;
  localparam logic   KIND_TICK   = 1'b0;
  localparam logic   KIND_WRITE  = 1'b1;

  typedef struct {
    logic        kind;
    logic        trigger;
    logic [8:0]  address;
    logic [14:0] sample;
  } env_req_t;

  typedef struct {
    logic [14:0] level;
    mode_e       mode;
    crossing_e   crossing;
  } env_sample_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;   // trigger, table_address, table_data
  logic [0:0]           s_axis_tuser = '0;   // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;        // level, mode, crossing
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_ATTACK_RATE;
  logic [RATE_W-1:0]    cfg_data_i = '0;

  wavetable_attack_release_envelope dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  env_req_t    req_q[$];
  env_sample_t pending_samples[$];
  int          fault_count = 0;
  int          cycle_count = 0;
  int          gap_left = 0;
  int          stall_left = 0;

  // envelope model state
  longint      attack_step  = ATTACK_RATE_RST;
  longint      release_step = RELEASE_RATE_RST;
  longint      peak_level   = PEAK_PHASE_RST;
  logic [14:0] wave_copy [0:TABLE_ENTRIES_DEF];
  longint      phase_now    = 0;
  longint      phase_before = 0;
  crossing_e   cross_q      = CROSS_NONE;
  mode_e       env_mode_q   = MODE_ATTACK;

  function automatic int draw_pause();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 17);
    return 0;
  endfunction

  function automatic env_sample_t step_envelope(input logic trig);
    longint      inc, ph, a, b, v;
    int          idx, nxt, dir;
    logic        wrap_lo, wrap_hi;
    env_sample_t r;
    inc = 0;
    wrap_lo = 1'b0;
    wrap_hi = 1'b0;
    case (env_mode_q)
      MODE_ATTACK: begin
        if (cross_q == CROSS_UP) begin
          env_mode_q = MODE_RELEASE;
          inc = release_step;
        end else inc = attack_step;
      end
      MODE_RELEASE: begin
        if (trig) begin
          env_mode_q = MODE_RETRIG;
          inc = -attack_step;
        end else if (cross_q == CROSS_END) begin
          env_mode_q = MODE_REST;
          phase_now = 1;
        end else inc = release_step;
      end
      MODE_RETRIG: begin
        if (cross_q == CROSS_DOWN) begin
          env_mode_q = MODE_RELEASE;
          inc = release_step;
        end else inc = -attack_step;
      end
      default: begin
        if (trig) begin
          env_mode_q = MODE_ATTACK;
          inc = attack_step;
        end
      end
    endcase

    // rates stay below the span, so one wrap always lands inside it
    ph = phase_now + inc;
    if (ph < 0) begin
      wrap_lo = 1'b1;
      ph += SPAN;
    end else if (ph > SPAN) begin
      wrap_hi = 1'b1;
      ph -= SPAN;
    end

    dir = int'(ph < peak_level) - int'(phase_before < peak_level);
    if (!wrap_lo && !wrap_hi) begin
      if (dir == 0) cross_q = CROSS_NONE;
      else if (dir < 0) cross_q = CROSS_UP;
      else cross_q = CROSS_DOWN;
    end else if (wrap_hi && dir == 1) cross_q = CROSS_END;
    else cross_q = CROSS_OTHER;

    phase_before = ph;
    phase_now = ph;

    idx = int'(ph >> FRACTION_BITS_DEF);
    if (idx > TABLE_ENTRIES_DEF) idx = TABLE_ENTRIES_DEF;
    nxt = (idx + 1 > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : idx + 1;
    a = longint'(wave_copy[idx]);
    b = longint'(wave_copy[nxt]);
    v = a + (((b - a) * (ph & FRAC_MASK)) >>> FRACTION_BITS_DEF);
    r.level = v[14:0];
    r.mode = env_mode_q;
    r.crossing = cross_q;
    return r;
  endfunction

  function automatic void apply_request(input env_req_t r);
    if (r.kind == KIND_WRITE) begin
      if (r.address <= TABLE_ENTRIES_DEF) wave_copy[r.address] = r.sample;
    end else pending_samples.push_back(step_envelope(r.trigger));
  endfunction

  function automatic void note_fault(input string what);
    if (fault_count < 10) $display("%s", what);
    fault_count++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : driver
    env_req_t sent;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sent = req_q.pop_front();
        apply_request(sent);
        gap_left = draw_pause();
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'd0, req_q[0].sample, req_q[0].address, req_q[0].trigger};
          s_axis_tuser <= req_q[0].kind;
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    env_sample_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_samples.size() == 0) begin
          note_fault($sformatf("unexpected result: level %0d mode %0d crossing %0d",
                               m_axis_tdata[14:0], m_axis_tdata[16:15], m_axis_tdata[19:17]));
        end else begin
          want = pending_samples.pop_front();
          if (m_axis_tdata[14:0] != want.level || m_axis_tdata[16:15] != want.mode ||
              m_axis_tdata[19:17] != want.crossing)
            note_fault($sformatf({"mismatch: level %0d/%0d mode %0d/%0d crossing %0d/%0d",
                                  " (expected/actual)"},
                                 want.level, m_axis_tdata[14:0], want.mode,
                                 m_axis_tdata[16:15], want.crossing, m_axis_tdata[19:17]));
        end
        stall_left = draw_pause();
      end else if (stall_left > 0) stall_left--;
      m_axis_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input cfg_index_e idx, input logic [RATE_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_ATTACK_RATE:  attack_step = longint'(val);
      CFG_RELEASE_RATE: release_step = longint'(val);
      default:          peak_level = longint'(val);
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_envelope(input logic [23:0] att, input logic [23:0] rel,
                              input logic [23:0] pk);
    write_reg(CFG_ATTACK_RATE, att);
    write_reg(CFG_RELEASE_RATE, rel);
    write_reg(CFG_PEAK_PHASE, pk);
    @(negedge clk_i);
  endtask

  // table writes cause no result, so allow the pipeline to drain as well
  task automatic wait_idle();
    while (req_q.size() != 0 || s_axis_tvalid || pending_samples.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic void queue_write(input int addr, input int data);
    req_q.push_back('{kind: KIND_WRITE, trigger: 1'b0, address: addr[8:0],
                      sample: data[14:0]});
  endfunction

  function automatic void queue_tick(input logic trig);
    req_q.push_back('{kind: KIND_TICK, trigger: trig, address: 9'd0, sample: 15'd0});
  endfunction

  function automatic logic [23:0] pick_rate();
    if ($urandom_range(0, 4) == 0) return 24'($urandom_range(0, 24'hFFFFFF));
    return 24'($urandom_range(24'h40000, 24'h400000));
  endfunction

  // mostly ticks, some triggers, a few table writes including ignored addresses
  function automatic void queue_random(input int count, input int trig_odds);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 6)
        queue_write($urandom_range(0, 511), $urandom_range(0, 32767));
      else queue_tick($urandom_range(1, trig_odds) == 1);
    end
  endfunction

  initial begin : stimulus
    int i;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i <= TABLE_ENTRIES_DEF; i++) begin
      if (i % 64 == 0) queue_write(i, 32767);
      else if (i % 64 == 1) queue_write(i, 0);
      else queue_write(i, $urandom_range(0, 32767));
    end
    wait_idle();

    // one whole envelope: up to the peak, on to exactly the span end, wrap, rest
    set_envelope(24'h100000, 24'h100000, 24'h800000);
    queue_write(257, 32767);
    queue_write(511, 15'h5555);
    queue_write(256, 32767);
    queue_tick(1'b0);
    queue_tick(1'b1);
    for (i = 0; i < 16; i++) queue_tick(1'b0);
    queue_tick(1'b1);
    queue_tick(1'b1);
    wait_idle();

    set_envelope(24'h180000, 24'h100000, 24'h800000);
    queue_random(32, 6);
    wait_idle();
    set_envelope(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    queue_random(32, 4);
    wait_idle();
    set_envelope(24'h200000, 24'h000000, 24'h000001);
    queue_random(32, 8);
    wait_idle();
    set_envelope(24'h000000, 24'h240000, 24'h400000);
    queue_random(16, 5);
    wait_idle();
    for (i = 0; i < 4; i++) begin
      set_envelope(pick_rate(), pick_rate(), 24'($urandom_range(1, 24'hFFFFFF)));
      queue_random(14, $urandom_range(3, 12));
      wait_idle();
    end

    if (fault_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wtenv_pkg.sv
hw/rtl/wtenv_cfg.sv
hw/rtl/wtenv_phase.sv
hw/rtl/wtenv_table.sv
hw/rtl/wtenv_interp.sv
hw/rtl/wavetable_attack_release_envelope.sv
dv/wavetable_attack_release_envelope_tb.sv
